/* src/keyboard_matrix_port_from_hid_keys_assert.svh */
// assertion macros for the checker file kmp_checker.sv
`ifndef KEYBOARD_MATRIX_PORT_FROM_HID_KEYS_ASSERT_SVH
`define KEYBOARD_MATRIX_PORT_FROM_HID_KEYS_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define KMP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, off while reset is asserted
`define KMP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, checked through reset as well
`define KMP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* src/kmp_pkg.sv */
package kmp_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int REPORT_KEYS = 6;
    localparam int ROWS        = 8;
    localparam int COLS        = 5;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_READ   = 2'd1,
        OP_OTHER  = 2'd2
    } kmp_opcode_t;

    localparam logic [7:0] CODE_BACKSPACE   = 8'h2a;
    localparam logic [7:0] CODE_PLACEHOLDER = 8'h91;
    localparam logic [7:0] MOD_CTRL_BITS    = 8'h11;
    localparam logic [7:0] MOD_SHIFT_BITS   = 8'h22;

    // rows with extra rules
    localparam int ROW_SHIFT = 0;
    localparam int ROW_BKSP  = 4;
    localparam int ROW_CTRL  = 7;

    localparam logic [0:ROWS-1][15:0] ROW_PORT = '{
        16'hfefe, 16'hfdfe, 16'hfbfe, 16'hf7fe,
        16'heffe, 16'hdffe, 16'hbffe, 16'h7ffe
    };

    localparam logic [0:ROWS-1][0:COLS-1][7:0] ROW_KEYS = '{
        '{CODE_PLACEHOLDER, 8'h1d, 8'h1b, 8'h06, 8'h19},
        '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0a},
        '{8'h14, 8'h1a, 8'h08, 8'h15, 8'h17},
        '{8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22},
        '{8'h27, 8'h26, 8'h25, 8'h24, 8'h23},
        '{8'h13, 8'h12, 8'h0c, 8'h18, 8'h1c},
        '{8'h28, 8'h0f, 8'h0e, 8'h0d, 8'h0b},
        '{8'h2c, CODE_PLACEHOLDER, 8'h10, 8'h11, 8'h05}
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  modifier_byte;
        logic [7:0]  key_0;
        logic [7:0]  key_1;
        logic [7:0]  key_2;
        logic [7:0]  key_3;
        logic [7:0]  key_4;
        logic [7:0]  key_5;
    } kmp_in_t;

    typedef struct packed {
        logic       decoded;
        logic [7:0] read_data;
    } kmp_out_t;

    typedef logic [KEY_SLOTS-1:0][7:0] kmp_keys_t;

    function automatic logic [7:0] report_key(input kmp_in_t item, input int idx);
        logic [7:0] k;
        case (idx)
            0:       k = item.key_0;
            1:       k = item.key_1;
            2:       k = item.key_2;
            3:       k = item.key_3;
            4:       k = item.key_4;
            5:       k = item.key_5;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

    function automatic logic key_held(input kmp_keys_t keys, input logic [7:0] code);
        logic hit;
        hit = 1'b0;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            hit = hit | (keys[s] == code);
        end
        return hit;
    endfunction

endpackage

/* src/keyboard_matrix_port_from_hid_keys.sv */
// Keyboard half-row port fed from USB HID key reports. Each transaction on s_ is
// either a key report (opcode 0), which replaces the held usage codes and modifier
// byte, or a bus access. A read (opcode 1) of one of the eight half-row ports
// 0xfefe..0x7ffe returns decoded=1 and an active-low key byte; anything else
// returns decoded=0 and read_data=0. Every transaction gives exactly one result
// on m_, in the output register or, if m_ stalls, the skid register. The decode
// is a single pass of parallel code compares, so one transaction is taken every
// cycle while s_ready is high; a skid register keeps s_ready high for one more
// transaction while m_ is stalled. A report is seen by the very next read.
module keyboard_matrix_port_from_hid_keys
    import kmp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kmp_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output kmp_out_t m_payload
);

    kmp_keys_t  held_keys_reg;
    logic [7:0] held_modifiers_reg;

    logic     out_valid_reg;
    kmp_out_t out_data_reg;
    logic     skid_valid_reg;
    kmp_out_t skid_data_reg;

    logic     s_accept;
    logic     out_free;
    kmp_out_t result;

    logic [ROWS-1:0]       port_hit;
    logic [ROWS-1:0][7:0]  row_val;

    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    // per-row key bytes and address match
    always_comb begin
        logic bksp;
        logic shift;
        logic ctrl;
        logic [7:0] sel;
        bksp  = key_held(held_keys_reg, CODE_BACKSPACE);
        shift = |(held_modifiers_reg & MOD_SHIFT_BITS);
        ctrl  = |(held_modifiers_reg & MOD_CTRL_BITS);
        sel   = 8'h00;
        for (int r = 0; r < ROWS; r++) begin
            port_hit[r] = (s_payload.bus_address == ROW_PORT[r]);
            row_val[r]  = 8'hff;
            for (int c = 0; c < COLS; c++) begin
                if (key_held(held_keys_reg, ROW_KEYS[r][c])) begin
                    row_val[r][c] = 1'b0;
                end
            end
            if (r == ROW_SHIFT && (bksp || shift)) begin
                row_val[r][0] = 1'b0;
            end
            if (r == ROW_BKSP && bksp) begin
                row_val[r][0] = 1'b0;
            end
            if (r == ROW_CTRL && ctrl) begin
                row_val[r][1] = 1'b0;
            end
            if (port_hit[r]) begin
                sel = sel | row_val[r];
            end
        end
        result.decoded   = 1'b0;
        result.read_data = 8'h00;
        if (s_payload.opcode == OP_READ && |port_hit) begin
            result.decoded   = 1'b1;
            result.read_data = sel;
        end
    end

    // held report; slots past the report width stay zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_keys_reg      <= '0;
            held_modifiers_reg <= '0;
        end else if (s_accept && s_payload.opcode == OP_REPORT) begin
            held_modifiers_reg <= s_payload.modifier_byte;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                if (s < REPORT_KEYS) begin
                    held_keys_reg[s] <= report_key(s_payload, s);
                end
            end
        end
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                out_data_reg <= result;
            end
        end else if (s_accept) begin
            skid_data_reg <= result;
        end
    end

endmodule

/* src/kmp_checker.sv */
`include "keyboard_matrix_port_from_hid_keys_assert.svh"

module kmp_checker
    import kmp_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input kmp_in_t  s_payload,
    input logic     m_valid,
    input logic     m_ready,
    input kmp_out_t m_payload
);

    // a stalled result holds
    `KMP_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // an accepted transaction on an empty output shows up next cycle
    `KMP_ASSERT_NEXT(a_result_next, aclk, aresetn, s_valid && s_ready && !m_valid, m_valid)

    `KMP_ASSERT_SAME(a_miss_zero, aclk, aresetn, m_valid && !m_payload.decoded, m_payload.read_data == 8'h00)

    // decoded half-row bytes keep the unused upper bits high
    `KMP_ASSERT_SAME(a_hit_upper, aclk, aresetn, m_valid && m_payload.decoded, m_payload.read_data[7:5] == 3'b111)

    `KMP_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind keyboard_matrix_port_from_hid_keys kmp_checker u_kmp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

/* tb/keyboard_matrix_port_from_hid_keys_tb.sv */
module keyboard_matrix_port_from_hid_keys_tb
    import kmp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] BACKSPACE_CODE = 8'h2a;
    localparam logic [7:0] UNSENT_CODE    = 8'h91;
    localparam logic [7:0] CTRL_MASK      = 8'h11;
    localparam logic [7:0] SHIFT_MASK     = 8'h22;

    localparam int SHIFT_ROW     = 0;
    localparam int BACKSPACE_ROW = 4;
    localparam int CTRL_ROW      = 7;

    // half-row port addresses, row 7 first
    localparam logic [7:0][15:0] HALF_ROW_PORT = {
        16'h7ffe, 16'hbffe, 16'hdffe, 16'heffe,
        16'hf7fe, 16'hfbfe, 16'hfdfe, 16'hfefe
    };

    // usage codes per row, column 4 in the top byte
    localparam logic [7:0][39:0] ROW_CODES = {
        {8'h05, 8'h11, 8'h10, UNSENT_CODE, 8'h2c},
        {8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h28},
        {8'h1c, 8'h18, 8'h0c, 8'h12, 8'h13},
        {8'h23, 8'h24, 8'h25, 8'h26, 8'h27},
        {8'h22, 8'h21, 8'h20, 8'h1f, 8'h1e},
        {8'h17, 8'h15, 8'h08, 8'h1a, 8'h14},
        {8'h0a, 8'h09, 8'h07, 8'h16, 8'h04},
        {8'h19, 8'h06, 8'h1b, 8'h1d, UNSENT_CODE}
    };

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    kmp_in_t  s_payload;
    logic     m_valid;
    logic     m_ready;
    kmp_out_t m_payload;

    keyboard_matrix_port_from_hid_keys dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    kmp_in_t    pending_accesses[$];
    kmp_out_t   expected_port_bytes[$];
    logic [7:0] held_code [KEY_SLOTS];
    logic [7:0] held_mods;
    logic       access_taken;
    logic       no_idle;
    int         mismatch_count;
    int         results_seen;
    int         send_gap;
    int         ready_hold;
    int         long_hold_mark;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic code_is_held(input logic [7:0] code);
        logic hit;
        hit = 1'b0;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            if (held_code[s] == code) hit = 1'b1;
        end
        return hit;
    endfunction

    // applies one transaction to the held report and returns the port answer
    function automatic kmp_out_t predict_port_result(input kmp_in_t item);
        kmp_out_t   res;
        logic [7:0] report_codes [6];
        logic [39:0] codes;
        int         row;
        res = '0;
        report_codes = '{item.key_0, item.key_1, item.key_2,
                         item.key_3, item.key_4, item.key_5};
        case (item.opcode)
            OP_REPORT: begin
                held_mods = item.modifier_byte;
                for (int s = 0; s < KEY_SLOTS && s < 6; s++) begin
                    held_code[s] = report_codes[s];
                end
            end
            OP_READ: begin
                row = -1;
                for (int r = 0; r < 8; r++) begin
                    if (item.bus_address == HALF_ROW_PORT[r]) row = r;
                end
                if (row >= 0) begin
                    res.decoded   = 1'b1;
                    res.read_data = 8'hff;
                    codes = ROW_CODES[row];
                    for (int c = 0; c < 5; c++) begin
                        if (code_is_held(codes[8*c +: 8])) res.read_data[c] = 1'b0;
                    end
                    if (row == SHIFT_ROW && (code_is_held(BACKSPACE_CODE) ||
                                             (held_mods & SHIFT_MASK) != 0)) begin
                        res.read_data[0] = 1'b0;
                    end
                    if (row == BACKSPACE_ROW && code_is_held(BACKSPACE_CODE)) begin
                        res.read_data[0] = 1'b0;
                    end
                    if (row == CTRL_ROW && (held_mods & CTRL_MASK) != 0) begin
                        res.read_data[1] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] random_code();
        int          roll;
        logic [39:0] codes;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            codes = ROW_CODES[$urandom_range(0, 7)];
            return codes[8*$urandom_range(0, 4) +: 8];
        end
        if (roll < 60) return BACKSPACE_CODE;
        if (roll < 68) return UNSENT_CODE;
        if (roll < 80) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic kmp_in_t random_access();
        kmp_in_t item;
        int      roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)      item.opcode = OP_REPORT;
        else if (roll < 85) item.opcode = OP_READ;
        else if (roll < 95) item.opcode = OP_OTHER;
        else                item.opcode = OP_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            item.bus_address = HALF_ROW_PORT[$urandom_range(0, 7)];
        end else if (roll < 80) begin
            // near miss: one address bit off
            item.bus_address = HALF_ROW_PORT[$urandom_range(0, 7)] ^
                               (16'h0001 << $urandom_range(0, 15));
        end else begin
            item.bus_address = 16'($urandom_range(0, 65535));
        end
        roll = $urandom_range(0, 99);
        if (roll < 30)      item.modifier_byte = 8'h00;
        else if (roll < 60) item.modifier_byte = 8'h01 << (4 * $urandom_range(0, 1) +
                                                            $urandom_range(0, 1));
        else                item.modifier_byte = 8'($urandom_range(0, 255));
        item.key_0 = random_code();
        item.key_1 = random_code();
        item.key_2 = random_code();
        item.key_3 = random_code();
        item.key_4 = random_code();
        item.key_5 = random_code();
        return item;
    endfunction

    // keys packed as key_0 in the top byte down to key_5
    function automatic kmp_in_t make_access(input logic [1:0] op, input logic [15:0] addr,
                                            input logic [7:0] mods, input logic [47:0] keys);
        return kmp_in_t'({op, addr, mods, keys});
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || access_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
                s_payload <= pending_accesses.pop_front();
                s_valid   <= 1'b1;
                send_gap  = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off every few hundred results
    always @(negedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (results_seen >= long_hold_mark) begin
            long_hold_mark += 300;
            ready_hold = 79;
            m_ready <= 1'b0;
        end else begin
            gap = pick_gap();
            if (gap > 0) begin
                ready_hold = gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result check first, then the prediction for the transaction taken at this edge
    always @(posedge aclk) begin
        kmp_out_t want;
        access_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_port_bytes.size() == 0) begin
                report_mismatch("unexpected result", m_payload, '0);
            end else begin
                want = expected_port_bytes.pop_front();
                if (m_payload.decoded !== want.decoded) begin
                    report_mismatch("decoded", 9'(m_payload.decoded), 9'(want.decoded));
                end
                if (m_payload.read_data !== want.read_data) begin
                    report_mismatch("read_data", 9'(m_payload.read_data),
                                    9'(want.read_data));
                end
            end
        end
        if (access_taken) expected_port_bytes.push_back(predict_port_result(s_payload));
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_payload      = '0;
        m_ready        = 1'b0;
        access_taken   = 1'b0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        send_gap       = 0;
        ready_hold     = 0;
        long_hold_mark = 150;
        held_mods      = '0;
        foreach (held_code[s]) held_code[s] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // nothing held after reset
        pending_accesses.push_back(make_access(OP_READ, 16'hfefe, 8'h00, '0));
        // all-ones report, all modifiers
        pending_accesses.push_back(make_access(OP_REPORT, 16'h0000, 8'hff, '1));
        pending_accesses.push_back(make_access(OP_READ, 16'h7ffe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'hfefe, 8'h00, '0));
        // whole shift row plus backspace
        pending_accesses.push_back(make_access(OP_REPORT, 16'hffff, 8'h00,
            {8'h1d, 8'h1b, 8'h06, 8'h19, UNSENT_CODE, BACKSPACE_CODE}));
        pending_accesses.push_back(make_access(OP_READ, 16'hfefe, 8'hff, '1));
        pending_accesses.push_back(make_access(OP_READ, 16'heffe, 8'h00, '0));
        // number row, left ctrl
        pending_accesses.push_back(make_access(OP_REPORT, 16'h0000, 8'h01,
            {8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h27}));
        pending_accesses.push_back(make_access(OP_READ, 16'hf7fe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'heffe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'h7ffe, 8'h00, '0));
        // space row with the unsent code, right ctrl
        pending_accesses.push_back(make_access(OP_REPORT, 16'h0000, 8'h10,
            {8'h2c, UNSENT_CODE, 8'h10, 8'h11, 8'h05, 8'h28}));
        pending_accesses.push_back(make_access(OP_READ, 16'h7ffe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'hbffe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_REPORT, 16'h0000, 8'h02, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'hfefe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_REPORT, 16'h0000, 8'h20,
            {8'h04, 8'h14, 8'h13, 8'h00, 8'h00, 8'h00}));
        pending_accesses.push_back(make_access(OP_READ, 16'hfefe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'hfdfe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'hfbfe, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'hdffe, 8'h00, '0));
        // not decoded: other access, unused opcode, stray addresses
        pending_accesses.push_back(make_access(OP_OTHER, 16'hfefe, 8'hff, '1));
        pending_accesses.push_back(make_access(OP_UNUSED, 16'hfefe, 8'hff, '1));
        pending_accesses.push_back(make_access(OP_READ, 16'hffff, 8'h00, '0));
        pending_accesses.push_back(make_access(OP_READ, 16'h0000, 8'h00, '0));

        while (pending_accesses.size() != 0 || s_valid || expected_port_bytes.size() != 0)
            @(posedge aclk);

        for (int chunk = 0; chunk < 6; chunk++) begin
            no_idle = (chunk == 2);
            repeat (100) pending_accesses.push_back(random_access());
            while (pending_accesses.size() != 0) @(posedge aclk);
            // sender pause until the block is empty
            if (chunk == 3) begin
                while (s_valid || expected_port_bytes.size() != 0) @(posedge aclk);
            end
        end
        no_idle = 1'b0;

        while (pending_accesses.size() != 0 || s_valid || expected_port_bytes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_port_bytes.size() == 0) begin
            $display("keyboard_matrix_port_from_hid_keys_tb passed");
        end else begin
            $display("keyboard_matrix_port_from_hid_keys_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("keyboard_matrix_port_from_hid_keys_tb failed");
        $finish;
    end

endmodule
